// ===== hdl/sensor_advert_frame_packer_assert.svh =====
// assertion macros for the sensor advert frame packer
`ifndef SENSOR_ADVERT_FRAME_PACKER_ASSERT_SVH
`define SENSOR_ADVERT_FRAME_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked every cycle out of reset
`define SAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define SAFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SAFP_ASSERT(lbl, prop, msg)
`define SAFP_ASSERT_IMP(lbl, ante, cons, msg)
`define SAFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/safp_pkg.sv =====
// shared types, constants and helpers of the sensor advert frame packer
`timescale 1ns / 1ps
`default_nettype none

package safp_pkg;

  localparam int MAX_ENTRIES     = 16;
  localparam int MAX_VALUE_BYTES = 4;
  localparam int FRAME_BYTES     = 24;

  localparam int CntW    = $clog2(MAX_ENTRIES + 1);
  localparam int LenW    = $clog2(MAX_VALUE_BYTES + 1);
  localparam int PosW    = $clog2(FRAME_BYTES + 1);
  localparam int SumW    = $clog2(FRAME_BYTES + MAX_VALUE_BYTES + 2);
  localparam int FlenW   = 5;
  localparam int NumRegs = 5;
  localparam int PAddrW  = $clog2(4 * NumRegs);
  localparam int RegIdxW = PAddrW - 2;

  // transaction kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_BUILD = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_UUID_LO = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] REG_UUID_HI = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] REG_VERSION = RegIdxW'(2);
  localparam logic [RegIdxW-1:0] REG_ENCRYPT = RegIdxW'(3);
  localparam logic [RegIdxW-1:0] REG_TRIGGER = RegIdxW'(4);

  localparam logic [7:0] UUID_LO_RST = 8'hD2;
  localparam logic [7:0] UUID_HI_RST = 8'hFC;
  localparam logic [7:0] VERSION_RST = 8'h40;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_TOO_LONG = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROTATE = 2'd2
  } chain_op_e;

  typedef struct packed {
    logic [7:0]      id;
    logic [LenW-1:0] len;
    logic [31:0]     val;
  } entry_t;

  typedef struct packed {
    chain_op_e op;
    entry_t    ent;
  } chain_ctl_t;

  typedef struct packed {
    logic [7:0] uuid_lo;
    logic [7:0] uuid_hi;
    logic [7:0] info;
  } frame_cfg_t;

  // value byte k of an entry, zero past the fourth byte
  function automatic logic [7:0] value_byte(logic [31:0] val, logic [LenW-1:0] k);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 4; i++) begin
      if (k == LenW'(i)) r = val[8*i +: 8];
    end
    return r;
  endfunction

  // id plus value bytes starting at position p stay inside the frame
  function automatic logic entry_fits(logic [PosW-1:0] p, logic [LenW-1:0] l);
    return (SumW'(p) + SumW'(l) + SumW'(1)) <= SumW'(FRAME_BYTES);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/safp_cell.sv =====
// one storage cell of the sorted entry chain
`timescale 1ns / 1ps
`default_nettype none

module safp_cell (
  input  logic                clk_i,
  input  safp_pkg::chain_ctl_t ctl_i,
  input  safp_pkg::entry_t    prev_i,
  input  safp_pkg::entry_t    next_i,
  input  logic                prev_gt_i,
  input  logic                occ_i,
  input  logic                at_free_i,
  output safp_pkg::entry_t    ent_o,
  output logic                gt_o
);
  import safp_pkg::*;

  entry_t ent_q, ent_d;

  // occupied and sorting after the new id: this cell moves one place back
  assign gt_o  = occ_i && (ent_q.id > ctl_i.ent.id);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (prev_gt_i) begin
          ent_d = prev_i;
        end else if (gt_o || at_free_i) begin
          ent_d = ctl_i.ent;
        end
      end
      OP_ROTATE: ent_d = next_i;
      default:   ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

// ===== hdl/safp_ctrl.sv =====
// transaction sequencer, frame byte generator and result register
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_advert_frame_packer_assert.svh"

module safp_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [7:0]                    object_id_i,
  input  logic [3:0]                    value_length_i,
  input  logic [31:0]                   value_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_frame_byte_o,
  output logic [7:0]                    out_byte_o,
  output logic                          last_o,
  output logic [1:0]                    status_o,
  output logic [safp_pkg::FlenW-1:0]    frame_length_o,
  input  safp_pkg::frame_cfg_t          cfg_i,
  input  safp_pkg::entry_t              head_i,
  input  safp_pkg::entry_t              next_i,
  output safp_pkg::chain_ctl_t          ctl_o,
  output logic [safp_pkg::CntW-1:0]     count_o
);
  import safp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HDR  = 4'b0010,
    ST_ENT  = 4'b0100,
    ST_REST = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  ent_q, ent_d;
  logic [CntW-1:0]  rot_q, rot_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [1:0]       hdr_q, hdr_d;
  logic [LenW-1:0]  byte_q, byte_d;

  logic             ovld_q, ovld_d;
  logic             ofrm_q, ofrm_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  status_e          ostat_q, ostat_d;
  logic [FlenW-1:0] oflen_q, oflen_d;

  logic             emit_ok, acc, len_ok, full, end_ent;
  logic             emit, more;
  logic [7:0]       emit_byte;
  logic [PosW-1:0]  pos_n;
  logic [CntW-1:0]  ent_n, rot_n;

  assign emit_ok    = !ovld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && emit_ok;
  assign acc        = in_valid_i && in_ready_o;
  assign len_ok     = value_length_i <= 4'(MAX_VALUE_BYTES);
  assign full       = count_q == CntW'(MAX_ENTRIES);
  assign end_ent    = byte_q == head_i.len;
  assign pos_n      = pos_q + 1'b1;
  assign ent_n      = ent_q + 1'b1;
  assign rot_n      = rot_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ent_d       = ent_q;
    rot_d       = rot_q;
    pos_d       = pos_q;
    hdr_d       = hdr_q;
    byte_d      = byte_q;
    ovld_d      = ovld_q && !out_ready_i;
    ofrm_d      = ofrm_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    ostat_d     = ostat_q;
    oflen_d     = oflen_q;
    ctl_o.op    = OP_HOLD;
    ctl_o.ent   = '{id: object_id_i, len: LenW'(value_length_i), val: value_bytes_i};
    emit        = 1'b0;
    more        = 1'b0;
    emit_byte   = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (kind_i)
            KIND_ADD: begin
              ovld_d  = 1'b1;
              ofrm_d  = 1'b0;
              obyte_d = 8'h00;
              olast_d = 1'b1;
              oflen_d = '0;
              if (!len_ok) begin
                ostat_d = STAT_TOO_LONG;
              end else if (full) begin
                ostat_d = STAT_FULL;
              end else begin
                ostat_d  = STAT_OK;
                ctl_o.op = OP_INSERT;
                count_d  = count_q + 1'b1;
              end
            end
            KIND_BUILD: begin
              state_d = ST_HDR;
              hdr_d   = 2'd0;
              pos_d   = '0;
              ent_d   = '0;
              rot_d   = '0;
              byte_d  = '0;
            end
            KIND_CLEAR: begin
              ovld_d  = 1'b1;
              ofrm_d  = 1'b0;
              obyte_d = 8'h00;
              olast_d = 1'b1;
              ostat_d = STAT_OK;
              oflen_d = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        if (emit_ok) begin
          emit  = 1'b1;
          pos_d = pos_n;
          hdr_d = hdr_q + 1'b1;
          case (hdr_q)
            2'd0: begin
              emit_byte = cfg_i.uuid_lo;
              more      = 1'b1;
            end
            2'd1: begin
              emit_byte = cfg_i.uuid_hi;
              more      = 1'b1;
            end
            default: begin
              emit_byte = cfg_i.info;
              more      = (count_q != '0) && entry_fits(pos_n, head_i.len);
              // nothing rotated yet, so the chain is already in place
              state_d   = more ? ST_ENT : ST_IDLE;
              byte_d    = '0;
            end
          endcase
        end
      end
      ST_ENT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          pos_d     = pos_n;
          emit_byte = (byte_q == '0) ? head_i.id
                                     : value_byte(head_i.val, LenW'(byte_q - 1'b1));
          if (!end_ent) begin
            more   = 1'b1;
            byte_d = byte_q + 1'b1;
          end else begin
            ctl_o.op = OP_ROTATE;
            rot_d    = rot_n;
            ent_d    = ent_n;
            byte_d   = '0;
            more     = (ent_n < count_q) && entry_fits(pos_n, next_i.len);
            if (!more) begin
              state_d = (rot_n == CntW'(MAX_ENTRIES)) ? ST_IDLE : ST_REST;
            end
          end
        end
      end
      ST_REST: begin
        ctl_o.op = OP_ROTATE;
        rot_d    = rot_n;
        if (rot_n == CntW'(MAX_ENTRIES)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      ovld_d  = 1'b1;
      ofrm_d  = 1'b1;
      obyte_d = emit_byte;
      olast_d = !more;
      ostat_d = STAT_OK;
      oflen_d = more ? '0 : FlenW'(pos_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ent_q   <= '0;
      rot_q   <= '0;
      pos_q   <= '0;
      hdr_q   <= 2'd0;
      byte_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ent_q   <= ent_d;
      rot_q   <= rot_d;
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      byte_q  <= byte_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ofrm_q  <= ofrm_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
    oflen_q <= oflen_d;
  end

  assign out_valid_o     = ovld_q;
  assign is_frame_byte_o = ofrm_q;
  assign out_byte_o      = obyte_q;
  assign last_o          = olast_q;
  assign status_o        = ostat_q;
  assign frame_length_o  = oflen_q;
  assign count_o         = count_q;

  `SAFP_ASSERT(a_count_max, count_q <= CntW'(MAX_ENTRIES), "entry count above store depth")
  `SAFP_ASSERT(a_pos_max, pos_q <= PosW'(FRAME_BYTES), "frame position past frame size")
  `SAFP_ASSERT_IMP(a_ent_valid, state_q == ST_ENT, ent_q < count_q, "emitting a missing entry")
  `SAFP_ASSERT_IMP(a_rest_rot, state_q == ST_REST, rot_q < CntW'(MAX_ENTRIES), "ring overturned")
  `SAFP_ASSERT_NEXT(a_build_start, acc && (kind_i == KIND_BUILD), state_q == ST_HDR && hdr_q == 2'd0, "build did not start with header")

endmodule

`default_nettype wire

// ===== hdl/sensor_advert_frame_packer.sv =====
// top level of the sensor advert frame packer: register port, entry chain, sequencer
`timescale 1ns / 1ps
`default_nettype none

// Packs measurement entries into a service-data advertising frame.
// An add transaction stores one entry (object id, 0..4 value bytes) and answers
// with one status result; a clear transaction empties the store and answers ok.
// A build transaction streams the frame one byte per result: uuid low, uuid high,
// device info (version bits, bit 0 if encrypted, bit 2 if trigger based), then the
// entries in ascending id order, equal ids in arrival order, each as id then value
// bytes, stopping at the first entry that would not fit. last marks the final
// result of every transaction and frame_length is given on the final frame byte.
// Entries live in a chain of cells kept sorted on insert: an add moves every cell
// with a larger id back by one place. A build reads the head cell and turns the
// ring one place per entry sent; after the last byte the ring keeps turning, one
// place a cycle, until it has made a full turn of the store depth, so the stored
// order is back in place. The result of an add or clear sits in the output
// register the cycle after it is taken. A build emits its frame bytes as the sink
// takes them, then turns the ring through the store positions not sent when some
// but not all were sent (not at all when the store is empty, as the ring never
// moved); the next transaction is taken after that. Kind 3 is taken and dropped
// with no result. Registers are read and written through the APB-style port at
// byte address 4*index; write them only while no transaction is in flight.

module sensor_advert_frame_packer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [safp_pkg::PAddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input transactions
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [7:0]                   object_id_i,
  input  logic [3:0]                   value_length_i,
  input  logic [31:0]                  value_bytes_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_frame_byte_o,
  output logic [7:0]                   out_byte_o,
  output logic                         last_o,
  output logic [1:0]                   status_o,
  output logic [4:0]                   frame_length_o
);
  import safp_pkg::*;

  // configuration registers
  logic [7:0] uuid_lo_q, uuid_hi_q, version_q;
  logic       encrypt_q, trigger_q;
  logic       cfg_wr;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[PAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_lo_q <= UUID_LO_RST;
      uuid_hi_q <= UUID_HI_RST;
      version_q <= VERSION_RST;
      encrypt_q <= 1'b0;
      trigger_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_UUID_LO: uuid_lo_q <= pwdata[7:0];
        REG_UUID_HI: uuid_hi_q <= pwdata[7:0];
        REG_VERSION: version_q <= pwdata[7:0];
        REG_ENCRYPT: encrypt_q <= pwdata[0];
        REG_TRIGGER: trigger_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_UUID_LO: prdata = {24'h0, uuid_lo_q};
      REG_UUID_HI: prdata = {24'h0, uuid_hi_q};
      REG_VERSION: prdata = {24'h0, version_q};
      REG_ENCRYPT: prdata = {31'h0, encrypt_q};
      REG_TRIGGER: prdata = {31'h0, trigger_q};
      default:     prdata = 32'h0;
    endcase
  end

  // header bytes handed to the sequencer, device info flags folded in
  frame_cfg_t frame_cfg;
  assign frame_cfg.uuid_lo = uuid_lo_q;
  assign frame_cfg.uuid_hi = uuid_hi_q;
  assign frame_cfg.info    = version_q | {5'b0, trigger_q, 1'b0, encrypt_q};

  // entry chain: cell 0 is the head, a rotation moves every cell one place forward
  localparam int NextHead = (MAX_ENTRIES > 1) ? 1 : 0;

  chain_ctl_t              chain_ctl;
  logic [CntW-1:0]         count;
  entry_t                  chain_ent [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  chain_gt;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    localparam int Prev = (i + MAX_ENTRIES - 1) % MAX_ENTRIES;
    localparam int Next = (i + 1) % MAX_ENTRIES;

    safp_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (chain_ctl),
      .prev_i    (chain_ent[Prev]),
      .next_i    (chain_ent[Next]),
      .prev_gt_i ((i == 0) ? 1'b0 : chain_gt[Prev]),
      .occ_i     (CntW'(i) < count),
      .at_free_i (CntW'(i) == count),
      .ent_o     (chain_ent[i]),
      .gt_o      (chain_gt[i])
    );
  end

  // sequencer and result register
  safp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .object_id_i     (object_id_i),
    .value_length_i  (value_length_i),
    .value_bytes_i   (value_bytes_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_frame_byte_o (is_frame_byte_o),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .status_o        (status_o),
    .frame_length_o  (frame_length_o),
    .cfg_i           (frame_cfg),
    .head_i          (chain_ent[0]),
    .next_i          (chain_ent[NextHead]),
    .ctl_o           (chain_ctl),
    .count_o         (count)
  );

endmodule

`default_nettype wire
